// ===== hw/rtl/dq_pkg.sv =====
// shared types and constants for the double-ended queue
package dq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_LOAD,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
    cnt_t     count;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

// ===== hw/rtl/dq_if.sv =====
// request and result channel interfaces of the double-ended queue
interface dq_req_if;
  import dq_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic signed [DATA_W-1:0] value;
  modport source(output valid, output req_type, output value, input ready);
  modport sink(input valid, input req_type, input value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic                     last_item;
  modport source(output valid, output data, output status, output count,
                 output last_item, input ready);
  modport sink(input valid, input data, input status, input count,
               input last_item, output ready);
endinterface

// ===== hw/rtl/dq_cell.sv =====
// one storage cell of the queue chain, holding the element at its position
module dq_cell (
  input  logic               clk,
  input  dq_pkg::idx_t       idx,
  input  dq_pkg::cell_ctrl_t ctrl,
  input  dq_pkg::data_t      left_data,
  input  dq_pkg::data_t      right_data,
  input  dq_pkg::data_t      head_data,
  output dq_pkg::data_t      data,
  output dq_pkg::data_t      tap
);
  import dq_pkg::*;

  cnt_t  pos;
  cnt_t  pos_plus1;
  data_t data_next;

  assign pos       = CNT_W'(idx);
  assign pos_plus1 = pos + CNT_W'(1);

  // cell holding the back element drives its tap for pop back
  assign tap = (pos_plus1 == ctrl.count) ? data : '0;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_SHR:  data_next = (pos == '0) ? ctrl.value : left_data;
      CELL_SHL:  data_next = right_data;
      CELL_LOAD: if (pos == ctrl.count) data_next = ctrl.value;
      CELL_ROT: begin
        if (pos_plus1 < ctrl.count) begin
          data_next = right_data;
        end else if (pos_plus1 == ctrl.count) begin
          data_next = head_data;
        end
      end
      default:   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// top level of the double-ended queue: control, cell chain and result register
// push front, push back, pop front and pop back: one transaction per cycle while the result
//   register is free to load; each result is loaded into the output register on acceptance
// dump of n elements: n results, one per cycle while the result register is free,
//   set by the rotation of the cell chain; next request taken once the final result is loaded
// reset clears the fill count, state and result valid; cell contents are left as they are
module double_ended_queue (
  input logic clk,
  input logic rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  // control state
  state_t state;
  state_t state_next;
  cnt_t   cnt;
  cnt_t   cnt_next;
  cnt_t   dump_idx;
  cnt_t   dump_idx_next;

  // result register
  logic                rsp_valid;
  data_t               rsp_data;
  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;
  logic                rsp_last;

  // result load from the control logic
  logic                res_load;
  data_t               res_data;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;

  logic       out_free;
  logic       in_fire;
  logic       is_full;
  logic       is_empty;
  cell_ctrl_t ctrl;

  // cell chain
  data_t cell_data [DEPTH];
  data_t cell_tap  [DEPTH];
  data_t back_data;

  assign out_free = !rsp_valid || rsp.ready;
  assign in_fire  = req.valid && req.ready;
  assign is_full  = (cnt == CNT_W'(DEPTH));
  assign is_empty = (cnt == '0);

  assign rsp.valid     = rsp_valid;
  assign rsp.data      = rsp_data;
  assign rsp.status    = rsp_status;
  assign rsp.count     = rsp_count;
  assign rsp.last_item = rsp_last;

  // cells: element k of the queue sits in cell k, front in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  ((i == 0) ? data_t'('0) : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? data_t'('0) : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .head_data  (cell_data[0]),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // only the back cell drives a nonzero tap
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && req.req_type == REQ_DUMP && !is_empty) state_next = ST_DUMP;
      end
      ST_DUMP: begin
        if (out_free && (dump_idx + CNT_W'(1)) == cnt) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: ready, cell control, result load and counters
  always_comb begin
    req.ready     = 1'b0;
    ctrl.op       = CELL_HOLD;
    ctrl.value    = req.value;
    ctrl.count    = cnt;
    res_load      = 1'b0;
    res_data      = '0;
    res_status    = STATUS_OK;
    res_last      = 1'b1;
    cnt_next      = cnt;
    dump_idx_next = dump_idx;
    case (state)
      ST_IDLE: begin
        req.ready = out_free;
        if (in_fire) begin
          case (req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = STATUS_FULL;
              end else begin
                ctrl.op  = (req.req_type == REQ_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                cnt_next = cnt + CNT_W'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              res_load = 1'b1;
              if (is_empty) begin
                res_status = STATUS_EMPTY;
              end else begin
                if (req.req_type == REQ_POP_FRONT) begin
                  ctrl.op  = CELL_SHL;
                  res_data = cell_data[0];
                end else begin
                  res_data = back_data;
                end
                cnt_next = cnt - CNT_W'(1);
              end
            end
            REQ_DUMP: begin
              // empty dump answers at once, otherwise the stream starts from the dump state
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = STATUS_EMPTY;
              end else begin
                dump_idx_next = '0;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_DUMP: begin
        // list the front cell and rotate the live cells by one
        if (out_free) begin
          ctrl.op       = CELL_ROT;
          res_load      = 1'b1;
          res_data      = cell_data[0];
          res_last      = (dump_idx + CNT_W'(1)) == cnt;
          dump_idx_next = dump_idx + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      dump_idx <= dump_idx_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, count reported after the transaction
  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_data   <= res_data;
      rsp_status <= res_status;
      rsp_count  <= COUNT_W'(cnt_next);
      rsp_last   <= res_last;
    end
  end

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// testbench for the double-ended queue: directed and random requests checked against a mirror
module tb_double_ended_queue;
  import dq_pkg::*;

  // one result transaction as it is expected on the output channel
  typedef struct {
    data_t                data;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count;
    logic                 last_item;
  } dq_result_t;

  localparam int HOLD_CYCLES = 60;  // long receiver hold-off in the pressure test
  localparam int TAIL_CYCLES = 20;  // quiet cycles after the last result
  localparam data_t VAL_MIN = data_t'(32'h8000_0000);
  localparam data_t VAL_MAX = data_t'(32'h7fff_ffff);

  logic clk = 1'b0;
  logic rst;

  dq_req_if req_if();
  dq_rsp_if rsp_if();

  double_ended_queue DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the queue contents, updated when a request is accepted
  data_t      mirror_cells [DEPTH];
  int         mirror_front;
  int         mirror_fill;
  // results owed by the block, oldest first
  dq_result_t owed_rsp [$];

  // shared switches between the test tasks and the receiver
  bit gaps_on;
  bit hold_rsp;

  int n_errors;
  int n_requests;
  int n_results;
  int n_dump_entries;
  int n_full_flags;
  int n_empty_flags;
  int n_unknown;

  // mostly short gaps, now and then a long one
  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // push values lean on the field extremes a fair part of the time
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      default: return data_t'($urandom());
    endcase
  endfunction

  task automatic owe_result(data_t data, logic [STATUS_W-1:0] status, bit last_item);
    dq_result_t r;
    r.data      = data;
    r.status    = status;
    r.count     = mirror_fill[COUNT_W-1:0];
    r.last_item = last_item;
    owed_rsp.push_back(r);
  endtask

  // apply one accepted request to the mirror and queue up what it should produce
  task automatic apply_to_mirror(logic [REQ_W-1:0] kind, data_t val);
    data_t taken;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (mirror_fill >= DEPTH) begin
          // full: queue untouched, flag only
          owe_result('0, STATUS_FULL, 1'b1);
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
            mirror_cells[mirror_front] = val;
          end else begin
            mirror_cells[(mirror_front + mirror_fill) % DEPTH] = val;
          end
          mirror_fill++;
          owe_result('0, STATUS_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (mirror_fill == 0) begin
          owe_result('0, STATUS_EMPTY, 1'b1);
        end else begin
          if (kind == REQ_POP_FRONT) begin
            taken = mirror_cells[mirror_front];
            mirror_front = (mirror_front + 1) % DEPTH;
          end else begin
            taken = mirror_cells[(mirror_front + mirror_fill - 1) % DEPTH];
          end
          mirror_fill--;
          owe_result(taken, STATUS_OK, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (mirror_fill == 0) begin
          owe_result('0, STATUS_EMPTY, 1'b1);
        end else begin
          // one result per element, front to back, last one marked
          for (int i = 0; i < mirror_fill; i++)
            owe_result(mirror_cells[(mirror_front + i) % DEPTH], STATUS_OK,
                       i == mirror_fill - 1);
        end
      end
      default: begin
        // unknown request codes leave the queue alone
        n_unknown++;
        owe_result('0, STATUS_OK, 1'b1);
      end
    endcase
  endtask

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [REQ_W-1:0] kind, data_t val);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat (rand_gap()) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= val;
    do @(posedge clk); while (!req_if.ready);
    apply_to_mirror(kind, val);
    n_requests++;
  endtask

  // sender pauses until every owed result has come back
  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (owed_rsp.size() != 0);
  endtask

  // removal and dump on an empty queue, plus the unknown request codes 5 and 7
  task automatic test_empty_queue();
    gaps_on = 1'b0;
    send_request(REQ_POP_FRONT, VAL_MAX);
    send_request(REQ_POP_BACK, VAL_MIN);
    send_request(REQ_DUMP, -1);
    send_request(REQ_W'(5), VAL_MIN);
    send_request(REQ_W'(7), VAL_MAX);
    wait_results_done();
  endtask

  // one element in the queue: removing it must leave the queue empty
  task automatic test_single_element();
    gaps_on = 1'b0;
    send_request(REQ_PUSH_FRONT, VAL_MIN);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_PUSH_BACK, VAL_MAX);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_PUSH_BACK, -1);
    send_request(REQ_DUMP, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_DUMP, '0);
    wait_results_done();
  endtask

  // fill past the front wrap, overflow from both ends, dump full, then empty it
  task automatic test_full_queue();
    gaps_on = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    send_request(REQ_PUSH_FRONT, VAL_MAX);
    send_request(REQ_PUSH_BACK, VAL_MIN);
    send_request(REQ_DUMP, '0);
    while (mirror_fill > 0)
      send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
    wait_results_done();
  endtask

  // receiver holds off for a long stretch while pushes and a dump keep coming, so the block backs up; then pops
  task automatic test_output_backpressure();
    gaps_on  = 1'b0;
    hold_rsp = 1'b1;
    for (int i = 0; i < 24; i++)
      send_request(i == 12 ? REQ_DUMP : REQ_PUSH_BACK, pick_value());
    wait_results_done();
    for (int i = 0; i < 6; i++)
      send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, '0);
    wait_results_done();
  endtask

  // random traffic with dumps and unknown codes, in fill and drain phases so the queue swings between empty and full
  task automatic test_random_traffic(int n_items, bit with_gaps);
    bit               filling;
    int               phase_left;
    int               pick;
    logic [REQ_W-1:0] kind;
    gaps_on    = with_gaps;
    filling    = 1'b0;
    phase_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 4)
        kind = REQ_W'($urandom_range(5, 7));
      else if (pick < 12)
        kind = REQ_DUMP;
      else if (pick < (filling ? 75 : 35))
        kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      else
        kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      send_request(kind, pick_value());
    end
    wait_results_done();
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // result receiver: random stalls, stretches without them, and the long hold-off
  initial begin
    int gap;
    gap = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        gap--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) gap = rand_gap();
      end
    end
  end

  // compare every accepted result transaction with the oldest owed one
  always @(posedge clk) begin : check_results
    dq_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (owed_rsp.size() == 0) begin
        $display("%0t: result with none expected, data %0d status %0d count %0d last %0d",
                 $time, rsp_if.data, rsp_if.status, rsp_if.count, rsp_if.last_item);
        n_errors++;
      end else begin
        want = owed_rsp.pop_front();
        check_field("data", want.data, rsp_if.data);
        check_field("status", want.status, rsp_if.status);
        check_field("count", want.count, rsp_if.count);
        check_field("last_item", want.last_item, rsp_if.last_item);
        if (want.status == STATUS_FULL) n_full_flags++;
        if (want.status == STATUS_EMPTY) n_empty_flags++;
        if (want.status == STATUS_OK && !(want.count == 0 && want.data == 0) &&
            !want.last_item)
          n_dump_entries++;
      end
    end
  end

  // guard against a hung block
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_FRONT;
    req_if.value    = '0;
    gaps_on         = 1'b0;
    hold_rsp        = 1'b0;
    mirror_front    = 0;
    mirror_fill     = 0;
    n_errors        = 0;
    n_requests      = 0;
    n_results       = 0;
    n_dump_entries  = 0;
    n_full_flags    = 0;
    n_empty_flags   = 0;
    n_unknown       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_single_element();
    test_full_queue();
    test_random_traffic(100, 1'b0);
    test_output_backpressure();
    test_random_traffic(150, 1'b1);

    // everything owed has arrived; give stray results a chance to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_rsp.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_rsp.size());
      n_errors++;
    end
    $display("covered %0d requests (%0d unknown codes) and %0d results",
             n_requests, n_unknown, n_results);
    $display("including %0d non-final dump entries, %0d full and %0d empty flags",
             n_dump_entries, n_full_flags, n_empty_flags);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_cell.sv
hw/rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
